// ===== hdl/bpagc_pkg.sv =====
// Package for the block pool allocator with mark-count collection.
// Holds sizes, codes, payload structs and the controller/datapath interface.
// No dependencies.
`default_nettype none
package bpagc_pkg;

    localparam int MAX_BLOCKS      = 16;
    localparam int MAX_BLOCK_SLOTS = 1024;
    localparam int BLK_W           = 4;
    localparam int CNT_W           = 5;
    localparam int SLOT_W          = 11;
    localparam int TOTAL_W         = 15;

    localparam logic [SLOT_W-1:0] MIN_SLOTS_RESET = 11'd128;
    localparam logic [SLOT_W-1:0] MARK_MAX        = 11'd2047;
    localparam logic [SLOT_W-1:0] SLOTS_LIMIT     = 11'd1024;
    localparam logic [CNT_W-1:0]  NO_BLOCK        = 5'h1F;
    localparam logic [CNT_W-1:0]  POOL_SIZE       = 5'd16;
    localparam logic [CNT_W-1:0]  GUARD_LIMIT     = 5'd16;

    typedef enum logic [1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_VISIT   = 2'd1,
        KIND_COLLECT = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_TOO_LONG  = 2'd2
    } status_code_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [10:0] alloc_length;
        logic [3:0]  visit_block;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  block_index;
        logic [9:0]  slot_offset;
        logic [14:0] freed_total;
    } result_t;

    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_A_INIT,
        OP_A_HEAD,
        OP_A_WALK,
        OP_A_UNLINK,
        OP_VISIT,
        OP_C_START,
        OP_C_STEP,
        OP_ERR1,
        OP_ERR2,
        OP_EMIT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_A_INIT,
        S_A_HEAD,
        S_A_WALK,
        S_A_UNLINK,
        S_VISIT,
        S_C_START,
        S_C_STEP,
        S_EMIT
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       too_long;
        logic       head_bad;
        logic       pool_full;
        logic       fits;
        logic       fill;
        logic       walk_fail;
        logic       coll_last;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hdl/bpagc_ctrl.sv =====
// Controller state machine for the block pool allocator.
// Sequences datapath operations; depends on bpagc_pkg.
`default_nettype none
module bpagc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire bpagc_pkg::dp_stat_t stat,
    output bpagc_pkg::cmd_t         cmd
);

    bpagc_pkg::state_t state_reg;
    bpagc_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpagc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bpagc_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = bpagc_pkg::S_DECODE;
                end
            end
            bpagc_pkg::S_DECODE:
            begin
                unique case (stat.kind)
                    bpagc_pkg::KIND_ALLOC:   state_next = bpagc_pkg::S_A_INIT;
                    bpagc_pkg::KIND_VISIT:   state_next = bpagc_pkg::S_VISIT;
                    bpagc_pkg::KIND_COLLECT: state_next = bpagc_pkg::S_C_START;
                    default:                 state_next = bpagc_pkg::S_EMIT;
                endcase
            end
            bpagc_pkg::S_A_INIT:
            begin
                state_next = stat.too_long ? bpagc_pkg::S_EMIT : bpagc_pkg::S_A_HEAD;
            end
            bpagc_pkg::S_A_HEAD:
            begin
                state_next = bpagc_pkg::S_A_WALK;
                if (stat.head_bad && stat.pool_full)
                begin
                    state_next = bpagc_pkg::S_EMIT;
                end
            end
            bpagc_pkg::S_A_WALK:
            begin
                priority if (stat.fits)
                begin
                    state_next = stat.fill ? bpagc_pkg::S_A_UNLINK : bpagc_pkg::S_EMIT;
                end
                else if (stat.walk_fail)
                begin
                    state_next = bpagc_pkg::S_EMIT;
                end
                else
                begin
                    state_next = bpagc_pkg::S_A_WALK;
                end
            end
            bpagc_pkg::S_A_UNLINK: state_next = bpagc_pkg::S_EMIT;
            bpagc_pkg::S_VISIT:    state_next = bpagc_pkg::S_EMIT;
            bpagc_pkg::S_C_START:  state_next = bpagc_pkg::S_C_STEP;
            bpagc_pkg::S_C_STEP:
            begin
                if (stat.coll_last)
                begin
                    state_next = bpagc_pkg::S_EMIT;
                end
            end
            bpagc_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = bpagc_pkg::S_IDLE;
                end
            end
            default: state_next = bpagc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op     = bpagc_pkg::OP_IDLE;
        item_stall = 1'b1;
        unique case (state_reg)
            bpagc_pkg::S_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                begin
                    cmd.op = bpagc_pkg::OP_LOAD;
                end
            end
            bpagc_pkg::S_A_INIT:
            begin
                cmd.op = stat.too_long ? bpagc_pkg::OP_ERR2 : bpagc_pkg::OP_A_INIT;
            end
            bpagc_pkg::S_A_HEAD:
            begin
                cmd.op = (stat.head_bad && stat.pool_full) ? bpagc_pkg::OP_ERR1
                                                           : bpagc_pkg::OP_A_HEAD;
            end
            bpagc_pkg::S_A_WALK:
            begin
                cmd.op = (!stat.fits && stat.walk_fail) ? bpagc_pkg::OP_ERR1
                                                        : bpagc_pkg::OP_A_WALK;
            end
            bpagc_pkg::S_A_UNLINK: cmd.op = bpagc_pkg::OP_A_UNLINK;
            bpagc_pkg::S_VISIT:    cmd.op = bpagc_pkg::OP_VISIT;
            bpagc_pkg::S_C_START:  cmd.op = bpagc_pkg::OP_C_START;
            bpagc_pkg::S_C_STEP:
            begin
                if (!stat.coll_last)
                begin
                    cmd.op = bpagc_pkg::OP_C_STEP;
                end
            end
            bpagc_pkg::S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.op = bpagc_pkg::OP_EMIT;
                end
            end
            default: cmd.op = bpagc_pkg::OP_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// ===== hdl/bpagc_dp.sv =====
// Datapath for the block pool allocator: block tables, free list, result register.
// Executes controller operations; depends on bpagc_pkg.
`default_nettype none
module bpagc_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bpagc_pkg::item_t    item,
    input  wire logic                cfg_valid,
    input  wire logic [10:0]         cfg_data,
    input  wire bpagc_pkg::cmd_t     cmd,
    output bpagc_pkg::dp_stat_t      stat,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output bpagc_pkg::result_t       result
);

    localparam int NB = bpagc_pkg::MAX_BLOCKS;

    logic [10:0] size_reg   [NB];
    logic [10:0] used_reg   [NB];
    logic [10:0] freed_reg  [NB];
    logic [10:0] marks_reg  [NB];
    logic [4:0]  link_reg   [NB];
    logic        listed_reg [NB];

    logic [4:0]  created_reg;
    logic [4:0]  head_reg;
    logic [10:0] min_reg;
    logic [1:0]  kind_reg;
    logic [10:0] len_reg;
    logic [3:0]  vb_reg;
    logic [3:0]  cur_reg;
    logic [3:0]  prev_reg;
    logic        prev_valid_reg;
    logic [4:0]  guard_reg;
    logic [4:0]  ci_reg;
    logic [1:0]  status_reg;
    logic [3:0]  blk_reg;
    logic [9:0]  off_reg;
    logic [14:0] total_reg;
    logic        out_valid_reg;
    bpagc_pkg::result_t out_reg;

    logic [10:0] eff_min;
    logic [10:0] want;
    logic [11:0] sum;
    logic [4:0]  nxt;
    logic        nxt_bad;
    logic [3:0]  nb;
    logic [4:0]  ci_dec;
    logic [3:0]  cb;
    logic [10:0] live;
    logic [10:0] gone;
    logic [10:0] nf;
    logic [4:0]  nl;
    logic [4:0]  uh;

    always_comb
    begin
        eff_min = min_reg;
        if (min_reg == 11'd0)
        begin
            eff_min = 11'd1;
        end
        else if (min_reg > bpagc_pkg::SLOTS_LIMIT)
        begin
            eff_min = bpagc_pkg::SLOTS_LIMIT;
        end
        want    = (len_reg > eff_min) ? len_reg : eff_min;
        sum     = {1'b0, used_reg[cur_reg]} + {1'b0, len_reg};
        nxt     = link_reg[cur_reg];
        nxt_bad = nxt >= created_reg;
        nb      = created_reg[3:0];
        ci_dec  = ci_reg - 5'd1;
        cb      = ci_dec[3:0];
        live    = used_reg[cb] - freed_reg[cb];
        gone    = (live > marks_reg[cb]) ? (live - marks_reg[cb]) : 11'd0;
        nf      = freed_reg[cb] + gone;
        nl      = link_reg[cur_reg];
        uh      = prev_valid_reg ? head_reg : nl;
    end

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.too_long  = len_reg > bpagc_pkg::SLOTS_LIMIT;
        stat.head_bad  = head_reg >= created_reg;
        stat.pool_full = created_reg == bpagc_pkg::POOL_SIZE;
        stat.fits      = !({1'b0, size_reg[cur_reg]} < sum);
        stat.fill      = sum == {1'b0, size_reg[cur_reg]};
        stat.walk_fail = (guard_reg > bpagc_pkg::GUARD_LIMIT)
                         || (nxt_bad && (created_reg == bpagc_pkg::POOL_SIZE));
        stat.coll_last = ci_reg == 5'd0;
        stat.out_free  = !out_valid_reg || !result_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NB; i++)
            begin
                size_reg[i]   <= 11'd0;
                used_reg[i]   <= 11'd0;
                freed_reg[i]  <= 11'd0;
                marks_reg[i]  <= 11'd0;
                link_reg[i]   <= bpagc_pkg::NO_BLOCK;
                listed_reg[i] <= 1'b0;
            end
            created_reg    <= 5'd0;
            head_reg       <= bpagc_pkg::NO_BLOCK;
            min_reg        <= bpagc_pkg::MIN_SLOTS_RESET;
            kind_reg       <= 2'd0;
            len_reg        <= 11'd0;
            vb_reg         <= 4'd0;
            cur_reg        <= 4'd0;
            prev_reg       <= 4'd0;
            prev_valid_reg <= 1'b0;
            guard_reg      <= 5'd0;
            ci_reg         <= 5'd0;
            status_reg     <= 2'd0;
            blk_reg        <= 4'd0;
            off_reg        <= 10'd0;
            total_reg      <= 15'd0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            if (cmd.op == bpagc_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                bpagc_pkg::OP_LOAD:
                begin
                    kind_reg   <= item.kind;
                    len_reg    <= item.alloc_length;
                    vb_reg     <= item.visit_block;
                    status_reg <= bpagc_pkg::ST_OK;
                    blk_reg    <= 4'd0;
                    off_reg    <= 10'd0;
                    total_reg  <= 15'd0;
                end
                bpagc_pkg::OP_A_INIT:
                begin
                    if (created_reg == 5'd0)
                    begin
                        size_reg[0]   <= eff_min;
                        used_reg[0]   <= 11'd0;
                        freed_reg[0]  <= 11'd0;
                        marks_reg[0]  <= 11'd0;
                        link_reg[0]   <= bpagc_pkg::NO_BLOCK;
                        listed_reg[0] <= 1'b1;
                        head_reg      <= 5'd0;
                        created_reg   <= 5'd1;
                    end
                end
                bpagc_pkg::OP_A_HEAD:
                begin
                    prev_valid_reg <= 1'b0;
                    guard_reg      <= 5'd0;
                    if (head_reg >= created_reg)
                    begin
                        size_reg[nb]   <= want;
                        used_reg[nb]   <= 11'd0;
                        freed_reg[nb]  <= 11'd0;
                        marks_reg[nb]  <= 11'd0;
                        link_reg[nb]   <= bpagc_pkg::NO_BLOCK;
                        listed_reg[nb] <= 1'b1;
                        head_reg       <= created_reg;
                        cur_reg        <= nb;
                        created_reg    <= created_reg + 5'd1;
                    end
                    else
                    begin
                        cur_reg <= head_reg[3:0];
                    end
                end
                bpagc_pkg::OP_A_WALK:
                begin
                    if (stat.fits)
                    begin
                        blk_reg           <= cur_reg;
                        off_reg           <= used_reg[cur_reg][9:0];
                        used_reg[cur_reg] <= sum[10:0];
                    end
                    else
                    begin
                        prev_reg       <= cur_reg;
                        prev_valid_reg <= 1'b1;
                        guard_reg      <= guard_reg + 5'd1;
                        if (nxt_bad)
                        begin
                            size_reg[nb]      <= want;
                            used_reg[nb]      <= 11'd0;
                            freed_reg[nb]     <= 11'd0;
                            marks_reg[nb]     <= 11'd0;
                            link_reg[nb]      <= bpagc_pkg::NO_BLOCK;
                            listed_reg[nb]    <= 1'b1;
                            link_reg[cur_reg] <= created_reg;
                            cur_reg           <= nb;
                            created_reg       <= created_reg + 5'd1;
                        end
                        else
                        begin
                            cur_reg <= nxt[3:0];
                        end
                    end
                end
                bpagc_pkg::OP_A_UNLINK:
                begin
                    if (prev_valid_reg)
                    begin
                        link_reg[prev_reg] <= nl;
                    end
                    else
                    begin
                        head_reg <= nl;
                    end
                    link_reg[cur_reg]   <= bpagc_pkg::NO_BLOCK;
                    listed_reg[cur_reg] <= 1'b0;
                    if (uh == bpagc_pkg::NO_BLOCK && created_reg != bpagc_pkg::POOL_SIZE)
                    begin
                        size_reg[nb]   <= eff_min;
                        used_reg[nb]   <= 11'd0;
                        freed_reg[nb]  <= 11'd0;
                        marks_reg[nb]  <= 11'd0;
                        link_reg[nb]   <= bpagc_pkg::NO_BLOCK;
                        listed_reg[nb] <= 1'b1;
                        head_reg       <= created_reg;
                        created_reg    <= created_reg + 5'd1;
                    end
                end
                bpagc_pkg::OP_VISIT:
                begin
                    if ({1'b0, vb_reg} < created_reg && marks_reg[vb_reg] != bpagc_pkg::MARK_MAX)
                    begin
                        marks_reg[vb_reg] <= marks_reg[vb_reg] + 11'd1;
                    end
                end
                bpagc_pkg::OP_C_START:
                begin
                    ci_reg <= created_reg;
                end
                bpagc_pkg::OP_C_STEP:
                begin
                    ci_reg        <= ci_dec;
                    marks_reg[cb] <= 11'd0;
                    if (gone != 11'd0)
                    begin
                        total_reg <= total_reg + {4'd0, gone};
                        if (nf == size_reg[cb])
                        begin
                            used_reg[cb]  <= 11'd0;
                            freed_reg[cb] <= 11'd0;
                            if (!listed_reg[cb])
                            begin
                                link_reg[cb]   <= head_reg;
                                head_reg       <= {1'b0, cb};
                                listed_reg[cb] <= 1'b1;
                            end
                        end
                        else
                        begin
                            freed_reg[cb] <= nf;
                        end
                    end
                end
                bpagc_pkg::OP_ERR1:
                begin
                    status_reg <= bpagc_pkg::ST_EXHAUSTED;
                end
                bpagc_pkg::OP_ERR2:
                begin
                    status_reg <= bpagc_pkg::ST_TOO_LONG;
                end
                bpagc_pkg::OP_EMIT:
                begin
                    out_reg.status      <= status_reg;
                    out_reg.block_index <= blk_reg;
                    out_reg.slot_offset <= off_reg;
                    out_reg.freed_total <= total_reg;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== hdl/block_pool_allocator_mark_gc_top.sv =====
// Visit bumps the block's mark count; an unused kind goes straight to the result. Allocate
//   checks the length, then the free-list head, walks the free list block by block and may
//   unlink a filled block; collect steps through every created block. Throughput: one item
//   at a time; the next transfer is taken only after the result is registered, later on stall.
// Reset clears all block tables and the free list and sets min_block_slots to 128;
//   no clearing pass follows. Depends on bpagc_pkg, bpagc_ctrl and bpagc_dp.
`default_nettype none
module block_pool_allocator_mark_gc_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire bpagc_pkg::item_t   item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output bpagc_pkg::result_t      result,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [10:0]        cfg_data
);

    bpagc_pkg::cmd_t     cmd;
    bpagc_pkg::dp_stat_t stat;

    assign cfg_ready = 1'b1;

    bpagc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    bpagc_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
`default_nettype wire
